>>> design/dtp_pkg.sv
// shared constants, record types and helper function of the decimal triple parser
package dtp_pkg;

    // number format
    localparam int FRAC_BITS   = 16;
    localparam int FRAC_DIGITS = 6;
    localparam int INT_LIMIT   = 999999999;

    // derived widths
    localparam int INT_W    = $clog2(INT_LIMIT + 1);
    localparam int FRAC_W   = $clog2(10 ** FRAC_DIGITS);
    localparam int DIV_W    = $clog2(10 ** FRAC_DIGITS + 1);
    localparam int CNT_W    = 3;
    localparam int QUO_W    = FRAC_BITS + 1;
    localparam int VALUE_W  = 47;
    localparam int COMP_W   = 2;
    localparam int MQ_DEPTH = 4;
    localparam int MQ_PTR_W = $clog2(MQ_DEPTH);

    // component codes
    localparam logic [COMP_W-1:0] COMP_X = 2'd0;
    localparam logic [COMP_W-1:0] COMP_Y = 2'd1;
    localparam logic [COMP_W-1:0] COMP_Z = 2'd2;

    // character codes
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // one finished number, as the parser hands it to the conversion side
    typedef struct packed {
        logic [COMP_W-1:0] component;
        logic [INT_W-1:0]  int_acc;
        logic [FRAC_W-1:0] frac_acc;
        logic [CNT_W-1:0]  frac_cnt;
        logic              neg;
        logic              bad;
        logic              miss;
        logic              last;
    } num_rec_t;

    // queue status seen by the neighbors
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // power of ten selected by the fraction digit count
    function automatic logic [DIV_W-1:0] pow10(input logic [CNT_W-1:0] n);
        logic [31:0] p;
        begin
            unique case (n)
                3'd0: p = 32'd1;
                3'd1: p = 32'd10;
                3'd2: p = 32'd100;
                3'd3: p = 32'd1000;
                3'd4: p = 32'd10000;
                3'd5: p = 32'd100000;
                3'd6: p = 32'd1000000;
                3'd7: p = 32'd10000000;
                default: p = 32'd1;
            endcase
            pow10 = p[DIV_W-1:0];
        end
    endfunction

endpackage

>>> design/dtp_front.sv
// character classifier and number parser, one character per cycle while the record queue is not full
module dtp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [7:0]           char_in,
    input  logic                 start_field,
    input  dtp_pkg::q_status_t   mq_status,
    output logic                 full,
    output logic                 rec_push,
    output dtp_pkg::num_rec_t    rec
);

    localparam int PROD_W = dtp_pkg::INT_W + 4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BLANKS,
        PH_START,
        PH_SIGNED,
        PH_INT,
        PH_POINT,
        PH_FRAC
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [dtp_pkg::COMP_W-1:0]      comp_reg, comp_next;
    logic [dtp_pkg::INT_W-1:0]       int_reg, int_next;
    logic [dtp_pkg::FRAC_W-1:0]      frac_reg, frac_next;
    logic [dtp_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            neg_reg, neg_next;
    logic                            bad_reg, bad_next;

    logic                            accept;
    logic                            finish;
    logic                            done;
    phase_t                          ph;
    logic [dtp_pkg::COMP_W-1:0]      comp_v;
    logic [dtp_pkg::INT_W-1:0]       int_v;
    logic [dtp_pkg::FRAC_W-1:0]      frac_v;
    logic [dtp_pkg::CNT_W-1:0]       cnt_v;
    logic                            neg_v;
    logic                            bad_v;

    logic                            is_digit;
    logic                            is_blank;
    logic [3:0]                      dig;
    logic [PROD_W-1:0]               int_prod;
    logic                            int_hold;
    logic                            int_over;
    logic [dtp_pkg::INT_W-1:0]       int_add_val;
    logic                            frac_room;
    logic [dtp_pkg::FRAC_W-1:0]      frac_prod;
    logic [dtp_pkg::FRAC_W-1:0]      frac_add_val;
    logic [dtp_pkg::CNT_W-1:0]       cnt_add_val;

    assign full   = mq_status.full;
    assign accept = push && !full;

    // character classes
    assign is_digit = (char_in >= dtp_pkg::CH_ZERO) && (char_in <= dtp_pkg::CH_NINE);
    assign is_blank = (char_in == dtp_pkg::CH_SPACE) || (char_in == dtp_pkg::CH_TAB);
    assign dig      = char_in[3:0];

    // starting point: a new field drops whatever was open
    always_comb
    begin
        if (start_field)
        begin
            comp_v = dtp_pkg::COMP_X;
            int_v  = '0;
            frac_v = '0;
            cnt_v  = '0;
            neg_v  = 1'b0;
        end
        else
        begin
            comp_v = comp_reg;
            int_v  = int_reg;
            frac_v = frac_reg;
            cnt_v  = cnt_reg;
            neg_v  = neg_reg;
        end
    end

    // integer digit accumulate with saturation
    always_comb
    begin
        int_prod = (PROD_W'(int_v) << 3) + (PROD_W'(int_v) << 1) + PROD_W'(dig);
        int_hold = PROD_W'(int_v) >= PROD_W'(dtp_pkg::INT_LIMIT);
        int_over = int_prod >= PROD_W'(dtp_pkg::INT_LIMIT);
        if (int_hold || int_over)
        begin
            int_add_val = dtp_pkg::INT_W'(dtp_pkg::INT_LIMIT);
        end
        else
        begin
            int_add_val = int_prod[dtp_pkg::INT_W-1:0];
        end
    end

    // fraction digit accumulate, extra digits dropped
    always_comb
    begin
        frac_room = cnt_v < dtp_pkg::CNT_W'(dtp_pkg::FRAC_DIGITS);
        frac_prod = (frac_v << 3) + (frac_v << 1) + dtp_pkg::FRAC_W'(dig);
        if (frac_room)
        begin
            frac_add_val = frac_prod;
            cnt_add_val  = cnt_v + 1'b1;
        end
        else
        begin
            frac_add_val = frac_v;
            cnt_add_val  = cnt_v;
        end
    end

    // parse step: phases fall through until the character is consumed
    always_comb
    begin
        ph       = start_field ? PH_BLANKS : phase_reg;
        bad_v    = start_field ? 1'b0 : bad_reg;
        int_next = int_v;
        frac_next = frac_v;
        cnt_next = cnt_v;
        neg_next = neg_v;
        done     = 1'b0;
        finish   = 1'b0;

        if (ph == PH_BLANKS)
        begin
            if (is_blank)
            begin
                done = 1'b1;
            end
            else
            begin
                ph = PH_START;
            end
        end
        if (!done && ph == PH_START)
        begin
            ph = PH_SIGNED;
            if (char_in == dtp_pkg::CH_MINUS)
            begin
                neg_next = 1'b1;
                done     = 1'b1;
            end
        end
        if (!done && ph == PH_SIGNED)
        begin
            ph = PH_INT;
            if (is_digit)
            begin
                int_next = int_add_val;
                bad_v    = bad_v || int_hold || int_over;
                done     = 1'b1;
            end
            else
            begin
                bad_v = 1'b1;
            end
        end
        if (!done && ph == PH_INT)
        begin
            done = 1'b1;
            if (is_digit)
            begin
                int_next = int_add_val;
                bad_v    = bad_v || int_hold || int_over;
            end
            else if (char_in == dtp_pkg::CH_POINT)
            begin
                ph = PH_POINT;
            end
            else
            begin
                finish = 1'b1;
            end
        end
        if (!done && ph == PH_POINT)
        begin
            done = 1'b1;
            if (is_digit)
            begin
                frac_next = frac_add_val;
                cnt_next  = cnt_add_val;
                ph        = PH_FRAC;
            end
            else
            begin
                bad_v  = 1'b1;
                finish = 1'b1;
            end
        end
        if (!done && ph == PH_FRAC)
        begin
            done = 1'b1;
            if (is_digit)
            begin
                frac_next = frac_add_val;
                cnt_next  = cnt_add_val;
            end
            else
            begin
                finish = 1'b1;
            end
        end
        if (!done)
        begin
            ph = PH_IDLE;
        end
        bad_next = bad_v;

        // finished record
        rec.component = comp_v;
        rec.int_acc   = int_next;
        rec.frac_acc  = frac_next;
        rec.frac_cnt  = cnt_next;
        rec.neg       = neg_next;
        rec.bad       = bad_v;
        rec.miss      = (comp_v != dtp_pkg::COMP_Z) && (char_in != dtp_pkg::CH_COMMA);
        rec.last      = (comp_v == dtp_pkg::COMP_Z);

        // next number or end of field
        phase_next = ph;
        comp_next  = comp_v;
        if (finish)
        begin
            int_next  = '0;
            frac_next = '0;
            cnt_next  = '0;
            neg_next  = 1'b0;
            bad_next  = 1'b0;
            if (comp_v != dtp_pkg::COMP_Z)
            begin
                comp_next  = comp_v + 1'b1;
                phase_next = PH_START;
            end
            else
            begin
                comp_next  = dtp_pkg::COMP_X;
                phase_next = PH_IDLE;
            end
        end
    end

    assign rec_push = accept && finish;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            comp_reg  <= dtp_pkg::COMP_X;
            int_reg   <= '0;
            frac_reg  <= '0;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
            bad_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            comp_reg  <= comp_next;
            int_reg   <= int_next;
            frac_reg  <= frac_next;
            cnt_reg   <= cnt_next;
            neg_reg   <= neg_next;
            bad_reg   <= bad_next;
        end
    end

    // checks
    a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rec_push && rec.last |=> phase_reg == PH_IDLE)
        else $error("parser not idle after third component");

    a_idle_comp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> comp_reg == dtp_pkg::COMP_X)
        else $error("idle parser holds a nonzero component");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        rec_push |-> !mq_status.full)
        else $error("record pushed into full queue");

endmodule

>>> design/dtp_queue.sv
// small queue of finished number records between parser and converter
module dtp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dtp_pkg::num_rec_t    push_data,
    input  logic                 pop,
    output dtp_pkg::num_rec_t    head,
    output dtp_pkg::q_status_t   status
);

    dtp_pkg::num_rec_t               mem [0:dtp_pkg::MQ_DEPTH-1];
    logic [dtp_pkg::MQ_PTR_W-1:0]    wr_ptr_reg;
    logic [dtp_pkg::MQ_PTR_W-1:0]    rd_ptr_reg;
    logic [dtp_pkg::MQ_PTR_W:0]      cnt_reg;
    logic                            do_push;
    logic                            do_pop;

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == (dtp_pkg::MQ_PTR_W + 1)'(dtp_pkg::MQ_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/dtp_back.sv
// fixed point conversion pipeline and result queue
module dtp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dtp_pkg::num_rec_t             head,
    input  dtp_pkg::q_status_t            mq_status,
    output logic                          mq_pop,
    input  logic                          pop,
    output logic                          empty,
    output logic [dtp_pkg::COMP_W-1:0]    component,
    output logic signed [dtp_pkg::VALUE_W-1:0] value,
    output logic                          bad_number,
    output logic                          missing_comma,
    output logic                          last
);

    localparam int NDIV = dtp_pkg::FRAC_BITS;

    typedef struct packed {
        logic [dtp_pkg::COMP_W-1:0] component;
        logic [dtp_pkg::INT_W-1:0]  int_acc;
        logic                       neg;
        logic                       bad;
        logic                       miss;
        logic                       last;
        logic [dtp_pkg::DIV_W-1:0]  div;
        logic [dtp_pkg::DIV_W-1:0]  rem;
        logic [dtp_pkg::QUO_W-1:0]  quo;
    } stage_t;

    typedef struct packed {
        logic [dtp_pkg::COMP_W-1:0]  component;
        logic [dtp_pkg::VALUE_W-1:0] mag;
        logic                        neg;
        logic                        bad;
        logic                        miss;
        logic                        last;
    } mag_t;

    typedef struct packed {
        logic [dtp_pkg::COMP_W-1:0]  component;
        logic [dtp_pkg::VALUE_W-1:0] value;
        logic                        bad;
        logic                        miss;
        logic                        last;
    } out_rec_t;

    stage_t                 stg_reg [0:NDIV];
    logic [NDIV:0]          stg_vld_reg;
    stage_t                 rnd_reg;
    logic                   rnd_vld_reg;
    mag_t                   mag_reg;
    logic                   mag_vld_reg;

    out_rec_t               oq_mem [0:1];
    logic                   oq_wr_reg;
    logic                   oq_rd_reg;
    logic [1:0]             oq_cnt_reg;
    logic                   oq_full;
    logic                   oq_push;
    logic                   oq_pop;
    out_rec_t               oq_in;

    logic                   adv;
    stage_t                 load;

    // one restoring division step: shift in one quotient bit
    function automatic stage_t div_step(input stage_t s);
        stage_t                       r;
        logic [dtp_pkg::DIV_W:0]      r2;
        logic [dtp_pkg::DIV_W:0]      diff;
        logic                         ge;
        begin
            r    = s;
            r2   = {s.rem, 1'b0};
            diff = r2 - {1'b0, s.div};
            ge   = (r2 >= {1'b0, s.div});
            r.rem = ge ? diff[dtp_pkg::DIV_W-1:0] : r2[dtp_pkg::DIV_W-1:0];
            r.quo = {s.quo[dtp_pkg::QUO_W-2:0], ge};
            div_step = r;
        end
    endfunction

    // round half up: remainder at least half the divisor
    function automatic stage_t round_step(input stage_t s);
        stage_t                  r;
        logic [dtp_pkg::DIV_W:0] r2;
        begin
            r     = s;
            r2    = {s.rem, 1'b0};
            r.quo = s.quo + dtp_pkg::QUO_W'(r2 >= {1'b0, s.div});
            round_step = r;
        end
    endfunction

    // pipeline moves as a whole while the result queue has room
    assign oq_full = (oq_cnt_reg == 2'd2);
    assign adv     = !oq_full;
    assign mq_pop  = adv && !mq_status.empty;

    // load stage: fraction digits over their power of ten
    always_comb
    begin
        load.component = head.component;
        load.int_acc   = head.int_acc;
        load.neg       = head.neg;
        load.bad       = head.bad;
        load.miss      = head.miss;
        load.last      = head.last;
        load.div       = dtp_pkg::pow10(head.frac_cnt);
        load.rem       = dtp_pkg::DIV_W'(head.frac_acc);
        load.quo       = '0;
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stg_reg[0] <= load;
            for (int k = 1; k <= NDIV; k++)
            begin
                stg_reg[k] <= div_step(stg_reg[k-1]);
            end
            rnd_reg <= round_step(stg_reg[NDIV]);
            mag_reg.component <= rnd_reg.component;
            mag_reg.mag       <= (dtp_pkg::VALUE_W'(rnd_reg.int_acc) << dtp_pkg::FRAC_BITS)
                                 + dtp_pkg::VALUE_W'(rnd_reg.quo);
            mag_reg.neg       <= rnd_reg.neg;
            mag_reg.bad       <= rnd_reg.bad;
            mag_reg.miss      <= rnd_reg.miss;
            mag_reg.last      <= rnd_reg.last;
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg <= '0;
            rnd_vld_reg <= 1'b0;
            mag_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            stg_vld_reg <= {stg_vld_reg[NDIV-1:0], mq_pop};
            rnd_vld_reg <= stg_vld_reg[NDIV];
            mag_vld_reg <= rnd_vld_reg;
        end
    end

    // sign applied on the way into the result queue
    always_comb
    begin
        oq_in.component = mag_reg.component;
        oq_in.value     = mag_reg.neg ? (dtp_pkg::VALUE_W'(0) - mag_reg.mag) : mag_reg.mag;
        oq_in.bad       = mag_reg.bad;
        oq_in.miss      = mag_reg.miss;
        oq_in.last      = mag_reg.last;
    end

    assign oq_push = adv && mag_vld_reg;
    assign oq_pop  = pop && !empty;
    assign empty   = (oq_cnt_reg == 2'd0);

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_mem[oq_wr_reg] <= oq_in;
        end
    end

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= 1'b0;
            oq_rd_reg  <= 1'b0;
            oq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wr_reg <= !oq_wr_reg;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= !oq_rd_reg;
            end
            if (oq_push && !oq_pop)
            begin
                oq_cnt_reg <= oq_cnt_reg + 2'd1;
            end
            else if (oq_pop && !oq_push)
            begin
                oq_cnt_reg <= oq_cnt_reg - 2'd1;
            end
        end
    end

    assign component     = oq_mem[oq_rd_reg].component;
    assign value         = oq_mem[oq_rd_reg].value;
    assign bad_number    = oq_mem[oq_rd_reg].bad;
    assign missing_comma = oq_mem[oq_rd_reg].miss;
    assign last          = oq_mem[oq_rd_reg].last;

    // checks
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_vld_reg |-> rnd_reg.quo <= (dtp_pkg::QUO_W'(1) << dtp_pkg::FRAC_BITS))
        else $error("rounded fraction beyond one");

    a_oq_count: assert property (@(posedge clk) disable iff (!rst_n)
        oq_cnt_reg != 2'd3)
        else $error("result queue count out of range");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(mag_vld_reg) && $stable(stg_vld_reg))
        else $error("pipeline moved while stalled");

endmodule

>>> design/decimal_triple_parser.sv
// top level of the decimal triple parser: parser, record queue, converter
//
// channel   dir  handshake          payload
// ---------------------------------------------------------------------------
// input     in   push / full        char_in[7:0], start_field
// result    out  pop / empty        component[1:0], value[46:0], bad_number,
//                                   missing_comma, last
//
// one character is taken every cycle while full is low; the parser state
// machine consumes it in the same cycle. a finished number goes through the
// record queue, the load stage, a divider stage for each quotient bit of the
// fraction, the round and add stages and the result queue write.
// reset clears all control state at once; no clearing pass.
// full rises only when the four-entry record queue fills, which happens when
// pop is held low long enough for the two-entry result queue to back up.
module decimal_triple_parser (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [7:0]                            char_in,
    input  logic                                  start_field,
    input  logic                                  pop,
    output logic                                  empty,
    output logic [dtp_pkg::COMP_W-1:0]            component,
    output logic signed [dtp_pkg::VALUE_W-1:0]    value,
    output logic                                  bad_number,
    output logic                                  missing_comma,
    output logic                                  last
);

    dtp_pkg::q_status_t  mq_status;
    dtp_pkg::num_rec_t   rec;
    dtp_pkg::num_rec_t   head;
    logic                rec_push;
    logic                mq_pop;

    // parser front
    dtp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .char_in     (char_in),
        .start_field (start_field),
        .mq_status   (mq_status),
        .full        (full),
        .rec_push    (rec_push),
        .rec         (rec)
    );

    // record queue
    dtp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_data (rec),
        .pop       (mq_pop),
        .head      (head),
        .status    (mq_status)
    );

    // conversion back end
    dtp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .mq_status     (mq_status),
        .mq_pop        (mq_pop),
        .pop           (pop),
        .empty         (empty),
        .component     (component),
        .value         (value),
        .bad_number    (bad_number),
        .missing_comma (missing_comma),
        .last          (last)
    );

endmodule

>>> bench/tb_top.sv
// self-checking testbench of the decimal triple parser
module tb_top;
    import dtp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 2 * (FRAC_BITS + 4);
    localparam int LONG_HOLD   = 1200;

    // parser phases of the predictor
    typedef enum logic [2:0] {
        PH_IDLE, PH_BLANKS, PH_START, PH_SIGNED, PH_INT, PH_POINT, PH_FRAC
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       sf;
    } char_req_t;

    typedef struct packed {
        logic [COMP_W-1:0]  comp;
        logic [VALUE_W-1:0] val;
        logic               bad;
        logic               miss;
        logic               last;
    } number_t;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      push          = 1'b0;
    logic                      full;
    logic [7:0]                char_in       = 8'h00;
    logic                      start_field   = 1'b0;
    logic                      pop           = 1'b0;
    logic                      empty;
    logic [COMP_W-1:0]         component;
    logic signed [VALUE_W-1:0] value;
    logic                      bad_number;
    logic                      missing_comma;
    logic                      last;

    char_req_t pending_chars[$];
    number_t   expected_numbers[$];

    logic req_taken    = 1'b0;
    logic result_taken = 1'b0;
    int   mismatches   = 0;
    int   results_seen = 0;
    int   cycle_count  = 0;

    // predictor state
    parse_phase_t ps_phase = PH_IDLE;
    logic [1:0]   ps_comp  = '0;
    logic [31:0]  ps_int   = '0;
    logic [31:0]  ps_frac  = '0;
    int           ps_fcnt  = 0;
    logic         ps_neg   = 1'b0;
    logic         ps_bad   = 1'b0;

    decimal_triple_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .char_in       (char_in),
        .start_field   (start_field),
        .pop           (pop),
        .empty         (empty),
        .component     (component),
        .value         (value),
        .bad_number    (bad_number),
        .missing_comma (missing_comma),
        .last          (last)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void clear_number();
        ps_int  = '0;
        ps_frac = '0;
        ps_fcnt = 0;
        ps_neg  = 1'b0;
        ps_bad  = 1'b0;
    endfunction

    // integer digit, saturating at the limit
    function automatic void add_int_digit(logic [7:0] c);
        logic [63:0] acc;
        if (ps_int >= INT_LIMIT)
        begin
            ps_bad = 1'b1;
            return;
        end
        acc = 64'(ps_int) * 10 + 64'(c - CH_ZERO);
        if (acc >= INT_LIMIT)
        begin
            acc    = INT_LIMIT;
            ps_bad = 1'b1;
        end
        ps_int = acc[31:0];
    endfunction

    // fraction digits beyond the kept count are dropped
    function automatic void add_frac_digit(logic [7:0] c);
        if (ps_fcnt < FRAC_DIGITS && ps_fcnt < 7)
        begin
            ps_frac = ps_frac * 10 + 32'(c - CH_ZERO);
            ps_fcnt++;
        end
    endfunction

    // finished number: fixed point conversion and one expected result
    function automatic void close_number(logic [7:0] c);
        logic [63:0] scale;
        logic [63:0] frac_fx;
        logic [63:0] mag;
        number_t     num;
        scale   = 64'd1;
        frac_fx = '0;
        for (int i = 0; i < ps_fcnt; i++)
            scale = scale * 10;
        if (ps_fcnt != 0)
            frac_fx = ((64'(ps_frac) << FRAC_BITS) + scale / 2) / scale;
        mag = (64'(ps_int) << FRAC_BITS) + frac_fx;
        if (ps_neg)
            mag = -mag;
        num.comp = ps_comp;
        num.val  = mag[VALUE_W-1:0];
        num.bad  = ps_bad;
        num.miss = (ps_comp < 2 && c != CH_COMMA);
        num.last = (ps_comp >= 2);
        expected_numbers.push_back(num);
        clear_number();
        if (ps_comp < 2)
        begin
            ps_comp++;
            ps_phase = PH_START;
        end
        else
        begin
            ps_comp  = '0;
            ps_phase = PH_IDLE;
        end
    endfunction

    // predictor: one accepted character
    function automatic void parse_char(logic [7:0] c, logic sf);
        bit done;
        done = 1'b0;
        if (sf)
        begin
            ps_comp = '0;
            clear_number();
            ps_phase = PH_BLANKS;
        end
        if (ps_phase == PH_BLANKS)
        begin
            if (c == CH_SPACE || c == CH_TAB)
                done = 1'b1;
            else
                ps_phase = PH_START;
        end
        if (!done && ps_phase == PH_START)
        begin
            ps_phase = PH_SIGNED;
            if (c == CH_MINUS)
            begin
                ps_neg = 1'b1;
                done   = 1'b1;
            end
        end
        if (!done && ps_phase == PH_SIGNED)
        begin
            ps_phase = PH_INT;
            if (is_digit(c))
            begin
                add_int_digit(c);
                done = 1'b1;
            end
            else
                ps_bad = 1'b1;
        end
        if (!done && ps_phase == PH_INT)
        begin
            done = 1'b1;
            if (is_digit(c))
                add_int_digit(c);
            else if (c == CH_POINT)
                ps_phase = PH_POINT;
            else
                close_number(c);
        end
        if (!done && ps_phase == PH_POINT)
        begin
            done = 1'b1;
            if (is_digit(c))
            begin
                add_frac_digit(c);
                ps_phase = PH_FRAC;
            end
            else
            begin
                ps_bad = 1'b1;
                close_number(c);
            end
        end
        if (!done && ps_phase == PH_FRAC)
        begin
            done = 1'b1;
            if (is_digit(c))
                add_frac_digit(c);
            else
                close_number(c);
        end
        if (!done)
            ps_phase = PH_IDLE;
    endfunction

    // gap lengths: mostly none or short, a few long, with idle-free bursts
    function automatic int draw_gap(inout int burst);
        int r;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sample both handshakes; predict accepted requests, check results
    always @(posedge clk)
    begin : sample_ports
        number_t got;
        number_t want;
        cycle_count++;
        req_taken    <= push && !full;
        result_taken <= pop && !empty;
        if (rst_n && push && !full)
            parse_char(char_in, start_field);
        if (rst_n && pop && !empty)
        begin
            got.comp = component;
            got.val  = value;
            got.bad  = bad_number;
            got.miss = missing_comma;
            got.last = last;
            results_seen++;
            if (expected_numbers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: comp=%0d value=%h bad=%b miss=%b last=%b",
                             got.comp, got.val, got.bad, got.miss, got.last);
            end
            else
            begin
                want = expected_numbers.pop_front();
                if (got.comp !== want.comp || got.val !== want.val || got.bad !== want.bad
                    || got.miss !== want.miss || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp comp=%0d value=%h bad=%b miss=%b last=%b,",
                                 want.comp, want.val, want.bad, want.miss, want.last,
                                 " got comp=%0d value=%h bad=%b miss=%b last=%b",
                                 got.comp, got.val, got.bad, got.miss, got.last);
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // request driver
    int tx_gap   = 0;
    int tx_burst = 0;

    always @(negedge clk)
    begin : drive_requests
        char_req_t item;
        if (rst_n && !(push && !req_taken))
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                push <= 1'b0;
            end
            else if (pending_chars.size() > 0)
            begin
                item = pending_chars.pop_front();
                char_in     <= item.ch;
                start_field <= item.sf;
                push        <= 1'b1;
                tx_gap = draw_gap(tx_burst);
            end
            else
                push <= 1'b0;
        end
    end

    // result receiver with random stalls and two long hold-offs
    int rx_gap   = 0;
    int rx_burst = 0;
    int rx_hold  = 0;

    always @(negedge clk)
    begin : drive_pop
        if (rst_n)
        begin
            if (result_taken)
            begin
                rx_gap = draw_gap(rx_burst);
                if (results_seen == 40 || results_seen == 150)
                    rx_hold = LONG_HOLD;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic put_char(logic [7:0] c, logic sf);
        char_req_t item;
        item.ch = c;
        item.sf = sf;
        pending_chars.push_back(item);
    endtask

    task automatic put_text(string s, logic sf_first);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i], (i == 0) ? sf_first : 1'b0);
    endtask

    // one number with random content; occasionally long digit runs
    task automatic make_number(ref logic [7:0] txt[$]);
        int r;
        int n_int;
        int n_frac;
        if ($urandom_range(0, 99) < 40)
            txt.push_back(CH_MINUS);
        r = $urandom_range(0, 99);
        n_int = (r < 5) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 11);
        for (int i = 0; i < n_int; i++)
            txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        r = $urandom_range(0, 99);
        if (r >= 50)
        begin
            txt.push_back(CH_POINT);
            n_frac = (r < 85) ? $urandom_range(1, 4) : (r < 93) ? $urandom_range(6, 9) : 0;
            for (int i = 0; i < n_frac; i++)
                txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    function automatic logic [7:0] pick_break();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return 8'h0A;
            2: return 8'h3B;
            3: return 8'h00;
            4: return 8'hFF;
            default: return 8'h78;
        endcase
    endfunction

    // random fields: mostly well formed, some cut short, some noise bytes
    task automatic make_fields(int n_chars);
        logic [7:0] txt[$];
        int         added;
        int         keep;
        int         r;
        added = 0;
        while (added < n_chars)
        begin
            txt.delete();
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                keep = $urandom_range(1, 6);
                for (int i = 0; i < keep; i++)
                    put_char(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
                added += keep;
            end
            else
            begin
                repeat ($urandom_range(0, 2))
                    txt.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                for (int k = 0; k < 3; k++)
                begin
                    make_number(txt);
                    if (k < 2)
                        txt.push_back(($urandom_range(0, 99) < 94) ? CH_COMMA : pick_break());
                    else
                        txt.push_back(pick_break());
                end
                keep = (r < 22) ? $urandom_range(1, txt.size() - 1) : txt.size();
                for (int i = 0; i < keep; i++)
                    put_char(txt[i], (i == 0));
                added += keep;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0 || push)
            @(posedge clk);
        while (expected_numbers.size() != 0)
            @(posedge clk);
    endtask

    // stimulus and end of run
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // bytes while idle are ignored
        put_char(8'h00, 1'b0);
        put_char(8'hFF, 1'b0);
        // leading blanks, negative number with fraction
        put_text("\t -1.5,", 1'b1);
        // no leading digit, then a separator that is not a comma
        put_text(".2", 1'b0);
        put_char(8'hFF, 1'b0);
        // point with no digit after it, terminator of z consumed
        put_text("7.,", 1'b0);
        // field cut off by a restart
        put_text("3,4", 1'b1);
        put_text("8,4,25 ", 1'b1);

        make_fields(500);
        // sender pause until every expected result is back
        wait_drained();
        repeat ($urandom_range(5, 30)) @(posedge clk);
        make_fields(500);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && expected_numbers.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
